@@ hdl/rgb2hsv_pkg.sv @@
// Shared types and constants of the RGB to HSV converter.
`default_nettype none
package rgb2hsv_pkg;

	// Width of one color channel.
	localparam int CH_W = 8;
	// Quotient bits produced by each pipelined divider, one bit per stage.
	localparam int DIV_BITS = 16;
	// Dividend width of the dividers.
	localparam int DIV_W = CH_W + DIV_BITS;
	// Width of the scaled hue difference 3840 * |diff|.
	localparam int HUE_NUM_W = 20;
	// Bits needed for a hue fraction of at most one sixth of the circle.
	localparam int HUE_QW = 12;
	// Width of the hue result.
	localparam int HUE_W = 15;
	// Width of the saturation result.
	localparam int SAT_W = 16;

	// Hue in units of 1/64 degree.
	localparam logic [HUE_W-1:0] HUE_OFS_RED   = 15'd0;
	localparam logic [HUE_W-1:0] HUE_OFS_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL      = 15'd23040;

	// Which channel holds the maximum, ties going to red, then green.
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// Classified pixel handed from the front part to the back part.
	typedef struct packed {
		logic [DIV_W-1:0]     sat_num;
		logic [HUE_NUM_W-1:0] hue_num;
		logic [CH_W-1:0]      max;
		logic [CH_W-1:0]      delta;
		sector_t              sector;
		logic                 neg;
		logic                 grey;
		logic                 black;
	} work_t;

	// Fields that travel beside the dividers.
	typedef struct packed {
		sector_t         sector;
		logic            neg;
		logic            grey;
		logic            black;
		logic [CH_W-1:0] bright;
	} side_t;

endpackage
`default_nettype wire

@@ hdl/rgb2hsv_front.sv @@
// Front part: splits a pixel into channels and classifies it for the dividers.
`default_nettype none
module rgb2hsv_front (
	input  wire logic [23:0]         color_word,
	output rgb2hsv_pkg::work_t       work
);

	logic [rgb2hsv_pkg::CH_W-1:0] red, green, blue;
	logic [rgb2hsv_pkg::CH_W-1:0] mx, mn, delta, mag;
	logic [rgb2hsv_pkg::CH_W:0]   diff;
	rgb2hsv_pkg::sector_t         sector;

	assign red   = color_word[7:0];
	assign green = color_word[15:8];
	assign blue  = color_word[23:16];

	// Pick the maximum channel in red, green, blue order and form the difference.
	always_comb begin
		if (red >= green && red >= blue) begin
			sector = rgb2hsv_pkg::SECT_RED;
			mx     = red;
			diff   = {1'b0, green} - {1'b0, blue};
		end else if (green >= blue) begin
			sector = rgb2hsv_pkg::SECT_GREEN;
			mx     = green;
			diff   = {1'b0, blue} - {1'b0, red};
		end else begin
			sector = rgb2hsv_pkg::SECT_BLUE;
			mx     = blue;
			diff   = {1'b0, red} - {1'b0, green};
		end
	end

	// Minimum channel and the spread of the pixel.
	always_comb begin
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
	end

	assign delta = mx - mn;

	// Magnitude of the signed channel difference.
	assign mag = diff[rgb2hsv_pkg::CH_W] ? rgb2hsv_pkg::CH_W'(-diff) : diff[rgb2hsv_pkg::CH_W-1:0];

	// Dividends: 65535 * delta and 3840 * |diff|, built from shifts.
	always_comb begin
		work.sat_num = {delta, 16'd0} - rgb2hsv_pkg::DIV_W'(delta);
		work.hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};
		work.max     = mx;
		work.delta   = delta;
		work.sector  = sector;
		work.neg     = diff[rgb2hsv_pkg::CH_W];
		work.grey    = (delta == '0);
		work.black   = (mx == '0);
	end

endmodule
`default_nettype wire

@@ hdl/rgb2hsv_queue.sv @@
// Short request queue between the front and back parts.
`default_nettype none
module rgb2hsv_queue #(
	parameter int QDEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  rgb2hsv_pkg::work_t push_data,
	output logic               full,
	output logic               valid,
	output rgb2hsv_pkg::work_t data
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	rgb2hsv_pkg::work_t mem_q [QDEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               push_ok, pop;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
		if (ptr == PW'(QDEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	assign full    = (count_q == CW'(QDEPTH));
	assign valid   = (count_q != '0);
	assign push_ok = push && !full;
	// The back part never stalls, so the head leaves as soon as it is present.
	assign pop     = valid;
	assign data    = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push_ok, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/rgb2hsv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rgb2hsv_div #(
	parameter int QW = 16
) (
	input  wire logic                                clk,
	input  wire logic [rgb2hsv_pkg::CH_W+QW-1:0]     num,
	input  wire logic [rgb2hsv_pkg::CH_W-1:0]        den,
	output logic      [QW-1:0]                       quo
);

	localparam int DW = rgb2hsv_pkg::CH_W;

	// The caller guarantees num < den * 2**QW, so the upper part starts below den.
	logic [DW-1:0] rem_s [QW-1];
	logic [QW-1:0] low_s [QW-1];
	logic [DW-1:0] den_s [QW-1];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_in, den_in;
		logic [QW-1:0] low_in, quo_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in = num[DW+QW-1:QW];
			assign low_in = num[QW-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// Shift in the next dividend bit and try to subtract the divisor.
		assign trial = {rem_in, low_in[QW-1]};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			quo_s[k] <= {quo_in[QW-2:0], ge};
		end

		if (k < QW - 1) begin : g_carry
			logic [DW:0] sub;

			assign sub = trial - {1'b0, den_in};

			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? sub[DW-1:0] : trial[DW-1:0];
				low_s[k] <= {low_in[QW-2:0], 1'b0};
				den_s[k] <= den_in;
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule
`default_nettype wire

@@ hdl/rgb2hsv_back.sv @@
// Back part: saturation and hue divisions, hue assembly and the result register.
`default_nettype none
module rgb2hsv_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  rgb2hsv_pkg::work_t                     in_work,
	output logic                                   done,
	output logic [rgb2hsv_pkg::HUE_W-1:0]          hue,
	output logic [rgb2hsv_pkg::SAT_W-1:0]          saturation,
	output logic [rgb2hsv_pkg::CH_W-1:0]           brightness
);

	localparam int NS = rgb2hsv_pkg::DIV_BITS;

	logic [NS-1:0]              sat_quo, hue_quo;
	logic                       vld_s  [NS];
	rgb2hsv_pkg::side_t         side_s [NS];
	rgb2hsv_pkg::side_t         side_in, side_out;
	logic [rgb2hsv_pkg::HUE_W-1:0] frac, base, hue_next;

	logic                               done_q;
	logic [rgb2hsv_pkg::HUE_W-1:0]      hue_q;
	logic [rgb2hsv_pkg::SAT_W-1:0]      sat_q;
	logic [rgb2hsv_pkg::CH_W-1:0]       bright_q;

	// Saturation: 65535 * delta / max.
	rgb2hsv_div #(.QW(NS)) u_sat_div (
		.clk (clk),
		.num (in_work.sat_num),
		.den (in_work.max),
		.quo (sat_quo)
	);

	// Hue fraction: 3840 * |diff| / delta.
	rgb2hsv_div #(.QW(NS)) u_hue_div (
		.clk (clk),
		.num (rgb2hsv_pkg::DIV_W'(in_work.hue_num)),
		.den (in_work.delta),
		.quo (hue_quo)
	);

	always_comb begin
		side_in.sector = in_work.sector;
		side_in.neg    = in_work.neg;
		side_in.grey   = in_work.grey;
		side_in.black  = in_work.black;
		side_in.bright = in_work.max;
	end

	// Side fields and valid bits follow the divider stages.
	for (genvar k = 0; k < NS; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= in_valid;
				end
			end
			always_ff @(posedge clk) begin
				side_s[k] <= side_in;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign side_out = side_s[NS-1];
	assign frac     = rgb2hsv_pkg::HUE_W'(hue_quo[rgb2hsv_pkg::HUE_QW-1:0]);

	// Sector offset; a negative red hue wraps around the full circle.
	always_comb begin
		case (side_out.sector)
			rgb2hsv_pkg::SECT_RED: begin
				base = (side_out.neg && frac != '0) ? rgb2hsv_pkg::HUE_FULL
				                                   : rgb2hsv_pkg::HUE_OFS_RED;
			end
			rgb2hsv_pkg::SECT_GREEN: base = rgb2hsv_pkg::HUE_OFS_GREEN;
			rgb2hsv_pkg::SECT_BLUE:  base = rgb2hsv_pkg::HUE_OFS_BLUE;
			default:                 base = rgb2hsv_pkg::HUE_OFS_RED;
		endcase
	end

	// Grey pixels have no hue.
	always_comb begin
		if (side_out.grey) begin
			hue_next = '0;
		end else if (side_out.neg) begin
			hue_next = base - frac;
		end else begin
			hue_next = base + frac;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[NS-1];
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (vld_s[NS-1]) begin
			hue_q    <= hue_next;
			sat_q    <= side_out.black ? '0 : sat_quo;
			bright_q <= side_out.bright;
		end
	end

	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

endmodule
`default_nettype wire

@@ hdl/rgb_to_hsv_converter.sv @@
// Top level of the RGB to HSV converter.
//
// Converts one packed pixel (red 7:0, green 15:8, blue 23:16) to hue in
// 1/64 degree units, saturation with 65535 as full scale, and brightness.
// A request is taken at a rising edge where start is high and busy is low.
// Each result is shown for one cycle with done high and is taken at the
// edge that ends that cycle.
// An accepted request passes through the queue stage, the two 16-stage
// dividers, which form one quotient bit per stage, and the result register.
// Throughput: one pixel per clock, back to back, with no gaps required,
// as long as QDEPTH is at least 2; with a depth of one, busy holds the
// sender back while the single entry waits to leave the queue.
// The front part writes requests into a short queue; the back part drains
// it every cycle, so busy only rises if the queue fills, which a back part
// that never waits does not allow for a QDEPTH of 2 or more.
// Reset clears the queue and all valid bits; no result appears afterward
// until a new request is accepted.
`default_nettype none
module rgb_to_hsv_converter #(
	parameter int QDEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [23:0] color_word,
	output logic             done,
	output logic [14:0]      hue,
	output logic [15:0]      saturation,
	output logic [7:0]       brightness
);

	rgb2hsv_pkg::work_t front_work, queue_work;
	logic               queue_full, queue_valid;

	// Classify the incoming pixel.
	rgb2hsv_front u_front (
		.color_word (color_word),
		.work       (front_work)
	);

	// Decouple the front from the dividers.
	rgb2hsv_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_data (front_work),
		.full      (queue_full),
		.valid     (queue_valid),
		.data      (queue_work)
	);

	// Divide and assemble the result.
	rgb2hsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (queue_valid),
		.in_work    (queue_work),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	assign busy = queue_full;

endmodule
`default_nettype wire

@@ hdl/rgb2hsv_checker.sv @@
// Port-level checker for the RGB to HSV converter and its bind.
`default_nettype none
module rgb2hsv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [14:0] hue,
	input wire logic [15:0] saturation,
	input wire logic [7:0]  brightness
);

	localparam int LAT = rgb2hsv_pkg::DIV_BITS + 2;

	// Every accepted request returns its result after the fixed latency.
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted request produced no result at the expected latency");

	// No result appears without a request accepted the fixed latency earlier.
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	// Hue stays below a full circle.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue < 15'd23040))
		else $error("hue out of range");

	// A black pixel has neither saturation nor hue.
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brightness == 8'd0) |-> (saturation == 16'd0 && hue == 15'd0))
		else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter rgb2hsv_checker u_rgb2hsv_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the RGB to HSV converter.
`timescale 1ns / 1ps
module tb;

	// One sixth of the hue circle in 1/64 degree units.
	localparam int HUE_SIXTH = 3840;
	localparam int SAT_FULL = 65535;
	localparam int N_RANDOM = 1200;
	// Cycles without any request or result taken before the run is abandoned.
	localparam int STALL_LIMIT = 2000;
	// Cycles to wait after the last result, well past the conversion latency.
	localparam int DRAIN_CYCLES = 40;
	// Accepted-request window in which the sender never idles.
	localparam int BURST_FROM = 500;
	localparam int BURST_TO = 800;

	// Expected conversion result of one pixel.
	typedef struct {
		logic [rgb2hsv_pkg::HUE_W-1:0] hue;
		logic [rgb2hsv_pkg::SAT_W-1:0] sat;
		logic [rgb2hsv_pkg::CH_W-1:0]  bright;
	} hsv_t;

	// Pending request; settle makes the sender wait for all results first.
	typedef struct {
		logic [23:0] pix;
		logic        settle;
	} pixel_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [23:0] color_word = '0;
	logic        busy;
	logic        done;
	logic [14:0] hue;
	logic [15:0] saturation;
	logic [7:0]  brightness;

	pixel_req_t pixel_queue[$];
	pixel_req_t next_req;
	hsv_t       hsv_expected[$];
	hsv_t       hsv_got;
	int         n_accepted = 0;
	int         n_errors = 0;
	int         stall_cycles = 0;
	logic       sender_idle;

	rgb_to_hsv_converter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.color_word (color_word),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always #1 clk = ~clk;

	// Convert one packed pixel to hue, saturation and value.
	function automatic hsv_t hsv_of(input logic [23:0] pix);
		int r, g, b, mx, mn, delta, diff, offs, h;
		rgb2hsv_pkg::sector_t sect;
		hsv_t res;
		r = int'(pix[7:0]);
		g = int'(pix[15:8]);
		b = int'(pix[23:16]);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		res.bright = rgb2hsv_pkg::CH_W'(mx);
		res.sat = (mx > 0) ? rgb2hsv_pkg::SAT_W'((SAT_FULL * delta) / mx) : '0;
		h = 0;
		if (delta > 0) begin
			// Ties on the maximum go to red first, then green.
			if (r == mx) sect = rgb2hsv_pkg::SECT_RED;
			else if (g == mx) sect = rgb2hsv_pkg::SECT_GREEN;
			else sect = rgb2hsv_pkg::SECT_BLUE;
			case (sect)
				rgb2hsv_pkg::SECT_RED: begin
					diff = g - b;
					offs = int'(rgb2hsv_pkg::HUE_OFS_RED);
				end
				rgb2hsv_pkg::SECT_GREEN: begin
					diff = b - r;
					offs = int'(rgb2hsv_pkg::HUE_OFS_GREEN);
				end
				default: begin
					diff = r - g;
					offs = int'(rgb2hsv_pkg::HUE_OFS_BLUE);
				end
			endcase
			// Integer division truncates toward zero, as the hue rule needs.
			h = offs + (HUE_SIXTH * diff) / delta;
			if (h < 0) h += int'(rgb2hsv_pkg::HUE_FULL);
		end
		res.hue = rgb2hsv_pkg::HUE_W'(h);
		return res;
	endfunction

	function automatic logic [23:0] rgb(input int r, input int g, input int b);
		return {8'(b), 8'(g), 8'(r)};
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		n_errors++;
	endtask

	// Sender: records each accepted request and presents the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			color_word <= '0;
		end else begin
			if (start && !busy) begin
				hsv_expected.push_back(hsv_of(color_word));
				n_accepted++;
			end
			if (n_accepted >= BURST_FROM && n_accepted < BURST_TO)
				sender_idle = 1'b0;
			else
				sender_idle = ($urandom_range(99) < 25);
			if (pixel_queue.size() > 0 && pixel_queue[0].settle && hsv_expected.size() != 0)
				sender_idle = 1'b1;
			if (start && busy) begin
				// Request not yet taken: hold it as it is.
			end else if (pixel_queue.size() > 0 && !sender_idle) begin
				next_req = pixel_queue.pop_front();
				start <= 1'b1;
				color_word <= next_req.pix;
			end else begin
				start <= 1'b0;
				color_word <= 24'($urandom);
			end
		end
	end

	// Receiver: every strobed result is checked against the oldest request.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (hsv_expected.size() == 0) begin
				flag_mismatch("result with no request outstanding");
			end else begin
				hsv_got = hsv_expected.pop_front();
				if (hue !== hsv_got.hue)
					flag_mismatch($sformatf("hue %0d, expected %0d", hue, hsv_got.hue));
				if (saturation !== hsv_got.sat)
					flag_mismatch($sformatf("saturation %0d, expected %0d",
						saturation, hsv_got.sat));
				if (brightness !== hsv_got.bright)
					flag_mismatch($sformatf("brightness %0d, expected %0d",
						brightness, hsv_got.bright));
			end
		end
	end

	// Watchdog on cycles where neither a request nor a result is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		pixel_req_t req;
		int kind, r, g, b, m;
		logic [23:0] directed[$];

		// Black, white, grey, pure primaries and the three kinds of tied maxima.
		directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00,
			24'hFF0000, 24'h00FFFF, 24'hFFFF00, 24'hFF00FF,
			// Red maximum with blue above green wraps the hue around.
			24'h0100FF, 24'hFE00FF,
			// Smallest non-black pixels in each channel.
			24'h000001, 24'h000100, 24'h010000,
			// Sector edges close to the next sector.
			24'h00FEFF, 24'hFEFF00, 24'hFF00FE,
			// Difference of one, and mixed patterns.
			24'h7F8080, 24'h80807F, 24'hAA55AA, 24'h55AA55, 24'h123456};
		foreach (directed[i]) begin
			req.pix = directed[i];
			req.settle = 1'b0;
			pixel_queue.push_back(req);
		end

		// Random pixels, mostly uniform, with greys, ties and near-greys mixed in.
		for (int i = 0; i < N_RANDOM; i++) begin
			kind = $urandom_range(99);
			if (kind < 60) begin
				req.pix = 24'($urandom);
			end else if (kind < 75) begin
				m = $urandom_range(255);
				req.pix = rgb(m, m, m);
			end else if (kind < 90) begin
				m = $urandom_range(255);
				r = m;
				g = m;
				b = $urandom_range(m);
				case ($urandom_range(2))
					0: req.pix = rgb(r, g, b);
					1: req.pix = rgb(b, r, g);
					default: req.pix = rgb(r, b, g);
				endcase
			end else begin
				m = $urandom_range(253) + 1;
				r = m + $urandom_range(2) - 1;
				g = m + $urandom_range(2) - 1;
				b = m + $urandom_range(2) - 1;
				req.pix = rgb(r, g, b);
			end
			req.settle = (i == 300 || i == 900);
			pixel_queue.push_back(req);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until all requests are taken and all results are in.
		while (pixel_queue.size() != 0 || start || hsv_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
